// ----- sv/piaw_pkg.sv -----
`timescale 1ns / 1ps
// piaw_pkg: shared types, register indexes, reset values and the microcode
// program of the PI regulator. No dependencies.
package piaw_pkg;

  localparam int StepW   = 4;
  localparam int MulW    = 33;
  localparam int ProdW   = 2 * MulW;
  localparam int AccW    = 96;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 48;

  typedef logic [StepW-1:0] step_t;

  // multiplier operand A
  typedef enum logic [2:0] {
    MA_ERR, MA_INT_LO, MA_INT_HI, MA_DIFF_LO, MA_DIFF_HI
  } mul_a_t;

  // multiplier operand B
  typedef enum logic [2:0] {
    MB_DT, MB_KP, MB_KI, MB_REC_LO, MB_REC_HI
  } mul_b_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD32, ACC_ADD64
  } acc_op_t;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_INTEG, ACT_PTERM, ACT_LIN, ACT_CLAMP, ACT_DIFF, ACT_BACKCALC, ACT_DONE
  } act_t;

  typedef enum logic {
    JMP_NONE, JMP_NO_BC
  } jmp_t;

  typedef struct packed {
    mul_a_t  mul_a;
    mul_b_t  mul_b;
    acc_op_t acc_op;
    act_t    act;
    jmp_t    jmp;
    step_t   target;
  } ctrl_t;

  localparam ctrl_t CtrlNop = '{MA_ERR, MB_DT, ACC_HOLD, ACT_NONE, JMP_NONE, '0};

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_INTEG_GAIN_REC = 3'd2,
    REG_DRIVE_MIN      = 3'd3,
    REG_DRIVE_MAX      = 3'd4,
    REG_TWO_INPUT_MODE = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        [31:0] prop_gain;
    logic        [31:0] integ_gain;
    logic        [47:0] integ_gain_reciprocal;
    logic signed [31:0] drive_min;
    logic signed [31:0] drive_max;
    logic               two_input_mode;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    prop_gain:             32'd1342177,
    integ_gain:            32'd6553600,
    integ_gain_reciprocal: 48'd10995116278,
    drive_min:             32'sd0,
    drive_max:             32'sd62259,
    two_input_mode:        1'b0
  };

  localparam step_t StepDone = 4'd14;

  // Program. A multiply issued in one step is in the product register the next.
  function automatic ctrl_t piaw_ucode(step_t s);
    ctrl_t w;
    w = CtrlNop;
    case (s)
      4'd0:  begin w.mul_a = MA_ERR;     w.mul_b = MB_DT; end
      4'd1:  begin w.act = ACT_INTEG;    w.mul_a = MA_ERR;     w.mul_b = MB_KP; end
      4'd2:  begin w.act = ACT_PTERM;    w.mul_a = MA_INT_LO;  w.mul_b = MB_KI; end
      4'd3:  begin w.acc_op = ACC_LOAD;  w.mul_a = MA_INT_HI;  w.mul_b = MB_KI; end
      4'd4:  begin w.acc_op = ACC_ADD32; end
      4'd5:  begin w.act = ACT_LIN; end
      4'd6:  begin w.act = ACT_CLAMP;    w.jmp = JMP_NO_BC;    w.target = StepDone; end
      4'd7:  begin w.act = ACT_DIFF; end
      4'd8:  begin w.mul_a = MA_DIFF_LO; w.mul_b = MB_REC_LO; end
      4'd9:  begin
        w.acc_op = ACC_LOAD;  w.mul_a = MA_DIFF_LO; w.mul_b = MB_REC_HI;
      end
      4'd10: begin
        w.acc_op = ACC_ADD32; w.mul_a = MA_DIFF_HI; w.mul_b = MB_REC_LO;
      end
      4'd11: begin
        w.acc_op = ACC_ADD32; w.mul_a = MA_DIFF_HI; w.mul_b = MB_REC_HI;
      end
      4'd12: begin w.acc_op = ACC_ADD64; end
      4'd13: begin w.act = ACT_BACKCALC; end
      default: begin w.act = ACT_DONE; end
    endcase
    return w;
  endfunction

endpackage

// ----- sv/pi_controller_antiwindup_core.sv -----
`timescale 1ns / 1ps
// pi_controller_antiwindup_core: PI regulator with back-calculation anti-windup.
// Depends on piaw_pkg, piaw_sequencer and piaw_datapath.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  cfg     | cfg_valid / cfg_ready      | cfg_index[2:0], cfg_data[47:0]
//  item    | item_valid / item_ready    | reference_or_error, measured, time_step
//  result  | result_valid / result_ready| drive_output
//
// Each item is stepped through the microcode program on the single shared 33x33
// multiplier; the back-calculation pass runs only when the output clamps. A new
// item is taken only once the program has finished with the last one.
// Reset is synchronous; it restores the register defaults, clears the
// integrator and marks the next beat as the first (zero effective step).
// A finished result waits in the output register; the next item is taken
// meanwhile, and the program only holds on its last step while that register
// is still full. cfg_ready is always high; writes belong to idle periods.
module pi_controller_antiwindup_core import piaw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic signed [31:0]  reference_or_error,
  input  logic signed [31:0]  measured,
  input  logic        [31:0]  time_step,
  output logic                result_valid,
  input  logic                result_ready,
  output logic signed [31:0]  drive_output
);

  cfg_t               cfg;
  ctrl_t              ctrl;
  logic               start;
  logic               idle;
  logic               done;
  logic               out_free;
  logic               bc_needed;
  logic signed [31:0] drive_value;

  assign cfg_ready  = 1'b1;
  assign item_ready = idle;
  assign start      = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  // register file; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_PROP_GAIN:      cfg.prop_gain             <= cfg_data[31:0];
        REG_INTEG_GAIN:     cfg.integ_gain            <= cfg_data[31:0];
        REG_INTEG_GAIN_REC: cfg.integ_gain_reciprocal <= cfg_data[47:0];
        REG_DRIVE_MIN:      cfg.drive_min             <= cfg_data[31:0];
        REG_DRIVE_MAX:      cfg.drive_max             <= cfg_data[31:0];
        REG_TWO_INPUT_MODE: cfg.two_input_mode        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  piaw_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .bc_needed (bc_needed),
    .out_free  (out_free),
    .idle      (idle),
    .done      (done),
    .ctrl      (ctrl)
  );

  piaw_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .capture            (start),
    .reference_or_error (reference_or_error),
    .measured           (measured),
    .time_step          (time_step),
    .cfg                (cfg),
    .ctrl               (ctrl),
    .bc_needed          (bc_needed),
    .drive_value        (drive_value)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) drive_output <= drive_value;
  end

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    start |=> !item_ready)
    else $error("item accepted while previous one still in progress");

endmodule

// ----- sv/piaw_sequencer.sv -----
`timescale 1ns / 1ps
// piaw_sequencer: step counter, program lookup and conditional jump.
// Depends on piaw_pkg.
module piaw_sequencer import piaw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  bc_needed,
  input  logic  out_free,
  output logic  idle,
  output logic  done,
  output ctrl_t ctrl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state, state_next;
  step_t  step, step_next;

  assign ctrl = (state == S_RUN) ? piaw_ucode(step) : CtrlNop;
  assign idle = (state == S_IDLE);
  assign done = (state == S_RUN) && (ctrl.act == ACT_DONE) && out_free;

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_RUN;
          step_next  = '0;
        end
      end
      S_RUN: begin
        priority if (ctrl.act == ACT_DONE) begin
          if (out_free) state_next = S_IDLE;
        end else if (ctrl.jmp == JMP_NO_BC && !bc_needed) begin
          step_next = ctrl.target;
        end else begin
          step_next = step + 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> (state == S_RUN && step == '0))
    else $error("sequencer did not start at step zero");

  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    done |=> (state == S_IDLE))
    else $error("sequencer did not return to idle after delivery");

endmodule

// ----- sv/piaw_datapath.sv -----
`timescale 1ns / 1ps
// piaw_datapath: error capture, shared 33x33 multiplier, accumulator,
// integrator and clamp logic driven by the control word. Depends on piaw_pkg.
module piaw_datapath import piaw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               capture,
  input  logic signed [31:0] reference_or_error,
  input  logic signed [31:0] measured,
  input  logic        [31:0] time_step,
  input  cfg_t               cfg,
  input  ctrl_t              ctrl,
  output logic               bc_needed,
  output logic signed [31:0] drive_value
);

  logic signed [31:0]     err;
  logic        [31:0]     dt;
  logic                   active;
  logic                   first_pending;
  logic signed [63:0]     integ;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0] acc, acc_next;
  logic signed [39:0]     pterm;
  logic signed [48:0]     lin;
  logic signed [31:0]     u;
  logic signed [40:0]     diff;

  logic signed [32:0]     err_wide;
  logic signed [31:0]     err_next;
  logic signed [MulW-1:0] mul_a, mul_b;
  logic signed [AccW-1:0] prod_ext;
  logic signed [64:0]     isum;
  logic signed [63:0]     isum_sat;
  logic signed [47:0]     iterm;
  logic signed [48:0]     lo_ext, hi_ext, lo_sel, u_sel;
  logic signed [63:0]     bc_val;
  logic                   bc_fits;

  // error, saturated difference in two-input mode
  always_comb begin
    err_wide = {reference_or_error[31], reference_or_error} - {measured[31], measured};
    if (!cfg.two_input_mode)
      err_next = reference_or_error;
    else if (err_wide[32] != err_wide[31])
      err_next = err_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else
      err_next = err_wide[31:0];
  end

  always_comb begin
    unique case (ctrl.mul_a)
      MA_ERR:     mul_a = {err[31], err};
      MA_INT_LO:  mul_a = {1'b0, integ[31:0]};
      MA_INT_HI:  mul_a = {integ[63], integ[63:32]};
      MA_DIFF_LO: mul_a = {1'b0, diff[31:0]};
      MA_DIFF_HI: mul_a = {{24{diff[40]}}, diff[40:32]};
      default:    mul_a = '0;
    endcase
    unique case (ctrl.mul_b)
      MB_DT:     mul_b = {1'b0, dt};
      MB_KP:     mul_b = {1'b0, cfg.prop_gain};
      MB_KI:     mul_b = {1'b0, cfg.integ_gain};
      MB_REC_LO: mul_b = {1'b0, cfg.integ_gain_reciprocal[31:0]};
      MB_REC_HI: mul_b = {17'b0, cfg.integ_gain_reciprocal[47:32]};
      default:   mul_b = '0;
    endcase
  end

  assign prod_ext = {{(AccW-ProdW){prod[ProdW-1]}}, prod};

  always_comb begin
    unique case (ctrl.acc_op)
      ACC_HOLD:  acc_next = acc;
      ACC_LOAD:  acc_next = prod_ext;
      ACC_ADD32: acc_next = acc + (prod_ext <<< 32);
      ACC_ADD64: acc_next = acc + (prod_ext <<< 64);
      default:   acc_next = acc;
    endcase
  end

  // integrator accumulate with saturation
  always_comb begin
    isum = {integ[63], integ} + {prod[63], prod[63:0]};
    if (isum[64] != isum[63])
      isum_sat = isum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    else
      isum_sat = isum[63:0];
  end

  // Q16.48 times Q16.16, floor back to Q16.16
  assign iterm = acc[AccW-1:48];

  // clamp: lower bound first, upper bound wins
  always_comb begin
    lo_ext = {{17{cfg.drive_min[31]}}, cfg.drive_min};
    hi_ext = {{17{cfg.drive_max[31]}}, cfg.drive_max};
    lo_sel = (lin < lo_ext) ? lo_ext : lin;
    u_sel  = (lo_sel > hi_ext) ? hi_ext : lo_sel;
  end

  assign bc_needed = (cfg.integ_gain != '0) && active && (u_sel != lin);

  // back-calculated integrator: product >> 8, saturated to 64 bits
  always_comb begin
    bc_fits = (&acc[AccW-1:71]) || !(|acc[AccW-1:71]);
    if (bc_fits)
      bc_val = acc[71:8];
    else
      bc_val = acc[AccW-1] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
      active        <= 1'b0;
      integ         <= '0;
    end else begin
      if (capture) begin
        first_pending <= 1'b0;
        active        <= !first_pending && (time_step != '0);
      end
      if (ctrl.act == ACT_INTEG && active)
        integ <= isum_sat;
      else if (ctrl.act == ACT_BACKCALC)
        integ <= bc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      err <= err_next;
      dt  <= time_step;
    end
    prod <= mul_a * mul_b;
    acc  <= acc_next;
    if (ctrl.act == ACT_PTERM) pterm <= prod[63:24];
    if (ctrl.act == ACT_LIN)   lin   <= {{9{pterm[39]}}, pterm} + {iterm[47], iterm};
    if (ctrl.act == ACT_CLAMP) u     <= u_sel[31:0];
    if (ctrl.act == ACT_DIFF)  diff  <= {{9{u[31]}}, u} - {pterm[39], pterm};
  end

  assign drive_value = u;

  a_integ_idle: assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == ACT_INTEG && !active) |=> $stable(integ))
    else $error("integrator moved on an inactive step");

  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == ACT_CLAMP && cfg.drive_min <= cfg.drive_max)
      |=> (u >= $past(cfg.drive_min) && u <= $past(cfg.drive_max)))
    else $error("clamped output outside limits");

endmodule
